### hdl/led_temporal_dither_assert.svh
// Assertion macros shared by the led_temporal_dither checker.
`ifndef LED_TEMPORAL_DITHER_ASSERT_SVH
`define LED_TEMPORAL_DITHER_ASSERT_SVH

// Clocked assertion, off while reset is asserted.
`define LTD_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("ltd: assertion failed");

// Clocked assertion that also holds during reset.
`define LTD_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk_i) prop) \
    else $error("ltd: assertion failed");

`endif

### hdl/ltd_pkg.sv
// Types and constants of the LED temporal dither.
package ltd_pkg;

  localparam int unsigned IDX_W       = 5;
  localparam int unsigned LEVEL_W     = 16;
  localparam int unsigned DEPTH_W     = 5;
  localparam int unsigned CHAN_W      = 8;
  localparam int unsigned RES_W       = 8;
  localparam int unsigned SHIFT_W     = 4;
  localparam int unsigned GRB_W       = 3 * CHAN_W;
  localparam int unsigned DEPTH_MIN   = 8;
  localparam int unsigned DEPTH_MAX   = 16;
  localparam logic [DEPTH_W-1:0] DEPTH_RESET = 5'd12;

  // One channel's result: output intensity and new residue.
  typedef struct packed {
    logic [CHAN_W-1:0] value;
    logic [RES_W-1:0]  residue;
  } chan_res_t;

endpackage

### hdl/ltd_ram.sv
// Generic single-write, single-read RAM with registered read data.
module ltd_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 32,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // read port, data held while not enabled
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### hdl/ltd_channel.sv
// One color channel: add residue, take top eight bits with clamp, keep low bits.
module ltd_channel (
  input  logic [ltd_pkg::LEVEL_W-1:0] level_i,
  input  logic [ltd_pkg::SHIFT_W-1:0] shift_i,
  input  logic [ltd_pkg::RES_W-1:0]   residue_i,
  output ltd_pkg::chan_res_t          result_o
);
  import ltd_pkg::*;

  logic [LEVEL_W-1:0] lvl_mask;
  logic [LEVEL_W-1:0] lvl;
  logic [LEVEL_W:0]   sum;
  logic [LEVEL_W:0]   value;
  logic [RES_W:0]     res_mask;

  // keep only bits below depth = shift + 8
  always_comb begin
    for (int b = 0; b < LEVEL_W; b++) begin
      lvl_mask[b] = (b < (int'(shift_i) + CHAN_W));
    end
  end

  assign lvl      = level_i & lvl_mask;
  assign sum      = {1'b0, lvl} + (LEVEL_W+1)'(residue_i);
  assign value    = sum >> shift_i;
  assign res_mask = ((RES_W+1)'(1) << shift_i) - (RES_W+1)'(1);

  // saturate at full scale; residue is the dropped low bits
  always_comb begin
    if (|value[LEVEL_W:CHAN_W]) begin
      result_o.value = {CHAN_W{1'b1}};
    end else begin
      result_o.value = value[CHAN_W-1:0];
    end
    result_o.residue = sum[RES_W-1:0] & res_mask[RES_W-1:0];
  end

endmodule

### hdl/led_temporal_dither.sv
// Top level of the LED temporal dither: residue RAM, pipeline and output register.
//
//   channel  direction  handshake                 payload
//   in       input      in_valid_i / in_stall_o   pixel_index_i, red/green/blue_level_i
//   out      output     out_valid_o / out_stall_i grb_word_o
//   cfg      input      cfg_we_i                  cfg_wdata_i (input_depth)
//
// One item per cycle sustained while the output is not stalled; an item passes
// the compute stage register and then the output register before it can leave.
// The residue RAM is read at accept and written back when the item leaves the
// compute stage; a back-to-back item for the same pixel takes the forwarded
// residue.
// Reset clears per-entry valid bits at once, so no clearing pass is needed.
// A stalled output holds; the input stalls only when the output register is
// full and stalled and the compute stage is occupied.
module led_temporal_dither #(
  parameter int unsigned STRING_LENGTH = 32
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [ltd_pkg::DEPTH_W-1:0] cfg_wdata_i,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [ltd_pkg::IDX_W-1:0]   pixel_index_i,
  input  logic [ltd_pkg::LEVEL_W-1:0] red_level_i,
  input  logic [ltd_pkg::LEVEL_W-1:0] green_level_i,
  input  logic [ltd_pkg::LEVEL_W-1:0] blue_level_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [ltd_pkg::GRB_W-1:0]   grb_word_o
);
  import ltd_pkg::*;

  localparam int unsigned IdxSpan  = 1 << IDX_W;
  localparam int unsigned MemDepth = (STRING_LENGTH < IdxSpan) ? STRING_LENGTH : IdxSpan;
  localparam int unsigned AddrW    = (MemDepth > 1) ? $clog2(MemDepth) : 1;
  localparam int unsigned MemW     = 3 * RES_W;

  // configuration register
  logic [DEPTH_W-1:0] depth_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      depth_q <= DEPTH_RESET;
    end else if (cfg_we_i) begin
      depth_q <= cfg_wdata_i;
    end
  end

  // clamped depth to shift amount
  logic [SHIFT_W-1:0] shift;
  always_comb begin
    if (depth_q < DEPTH_W'(DEPTH_MIN)) begin
      shift = '0;
    end else if (depth_q > DEPTH_W'(DEPTH_MAX)) begin
      shift = SHIFT_W'(DEPTH_MAX - DEPTH_MIN);
    end else begin
      shift = SHIFT_W'(depth_q - DEPTH_W'(DEPTH_MIN));
    end
  end

  // pipeline control
  logic s1_valid_q, out_valid_q;
  logic s1_adv, in_acc;
  assign s1_adv     = s1_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = s1_valid_q && !s1_adv;
  assign in_acc     = in_valid_i && !in_stall_o;

  // input side address decode
  logic             in_ok;
  logic [AddrW-1:0] in_addr;
  assign in_ok   = (32'(pixel_index_i) < STRING_LENGTH);
  assign in_addr = pixel_index_i[AddrW-1:0];

  // compute stage registers
  logic               s1_ok_q, s1_hit_q, s1_ent_q;
  logic [AddrW-1:0]   s1_addr_q;
  logic [LEVEL_W-1:0] s1_red_q, s1_green_q, s1_blue_q;
  logic [MemW-1:0]    s1_fwd_q;

  logic            ram_we;
  logic [MemW-1:0] ram_wdata, ram_rdata;
  logic [MemDepth-1:0] ent_vld_q;

  assign ram_we = s1_adv && s1_ok_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_acc) begin
      s1_valid_q <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_q <= 1'b0;
    end
  end

  // payload and forwarding capture at accept
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_ok_q    <= in_ok;
      s1_addr_q  <= in_addr;
      s1_red_q   <= red_level_i;
      s1_green_q <= green_level_i;
      s1_blue_q  <= blue_level_i;
      s1_hit_q   <= ram_we && (s1_addr_q == in_addr);
      s1_fwd_q   <= ram_wdata;
      s1_ent_q   <= in_ok && ent_vld_q[in_addr];
    end
  end

  // per-entry valid bits: unwritten entries read as zero residue
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ent_vld_q <= '0;
    end else if (ram_we) begin
      ent_vld_q[s1_addr_q] <= 1'b1;
    end
  end

  ltd_ram #(
    .Width (MemW),
    .Depth (MemDepth)
  ) u_res_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (s1_addr_q),
    .wdata_i (ram_wdata),
    .re_i    (in_acc),
    .raddr_i (in_addr),
    .rdata_o (ram_rdata)
  );

  // residue select: out of range, forwarded, stored or reset value
  logic [MemW-1:0] res_cur;
  always_comb begin
    if (!s1_ok_q) begin
      res_cur = '0;
    end else if (s1_hit_q) begin
      res_cur = s1_fwd_q;
    end else if (s1_ent_q) begin
      res_cur = ram_rdata;
    end else begin
      res_cur = '0;
    end
  end

  // residue word layout: green, red, blue
  chan_res_t red_res, green_res, blue_res;

  ltd_channel u_red (
    .level_i   (s1_red_q),
    .shift_i   (shift),
    .residue_i (res_cur[2*RES_W-1:RES_W]),
    .result_o  (red_res)
  );

  ltd_channel u_green (
    .level_i   (s1_green_q),
    .shift_i   (shift),
    .residue_i (res_cur[3*RES_W-1:2*RES_W]),
    .result_o  (green_res)
  );

  ltd_channel u_blue (
    .level_i   (s1_blue_q),
    .shift_i   (shift),
    .residue_i (res_cur[RES_W-1:0]),
    .result_o  (blue_res)
  );

  assign ram_wdata = {green_res.residue, red_res.residue, blue_res.residue};

  // output register
  logic [GRB_W-1:0] grb_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_adv) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      grb_q <= {green_res.value, red_res.value, blue_res.value};
    end
  end

  assign out_valid_o = out_valid_q;
  assign grb_word_o  = grb_q;

endmodule

### hdl/ltd_checker.sv
// Port-level checker for the LED temporal dither, bound to the top level.
`include "led_temporal_dither_assert.svh"

module ltd_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        in_valid_i,
  input logic                        in_stall_o,
  input logic                        out_valid_o,
  input logic                        out_stall_i,
  input logic [ltd_pkg::GRB_W-1:0]   grb_word_o
);

  // a stalled result holds
  `LTD_ASSERT(a_out_hold, (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(grb_word_o)))

  // an accepted item is followed by a valid output after the compute stage and output register
  `LTD_ASSERT(a_latency, (in_valid_i && !in_stall_o) |-> ##2 out_valid_o)

  // input backpressure only comes from a full, stalled output
  `LTD_ASSERT_ALWAYS(a_stall_cause, in_stall_o |-> (out_valid_o && out_stall_i))

  // no result once reset has been seen at an edge
  `LTD_ASSERT_ALWAYS(a_reset_quiet, !rst_ni |=> !out_valid_o)

endmodule

bind led_temporal_dither ltd_checker u_ltd_checker (.*);

### bench/led_temporal_dither_tb.sv
// Self-checking testbench for the LED temporal dither: random pixels, a planned series of depths and random idling.
module led_temporal_dither_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import ltd_pkg::*;

  localparam int unsigned PIXELS      = 32;
  localparam int unsigned HOLD_CYCLES = 60;
  localparam int unsigned STUCK_LIMIT = 2000;
  localparam int unsigned RAND_ITEMS  = 50;

  typedef struct {
    logic [IDX_W-1:0]   idx;
    logic [LEVEL_W-1:0] red;
    logic [LEVEL_W-1:0] green;
    logic [LEVEL_W-1:0] blue;
    int unsigned        gap;
  } pixel_item_t;

  logic clk_i = 1'b0;
  logic rst_n = 1'b0;

  logic               cfg_we    = 1'b0;
  logic [DEPTH_W-1:0] cfg_wdata = '0;
  logic               in_valid  = 1'b0;
  logic               in_stall_o;
  logic [IDX_W-1:0]   pixel_index = '0;
  logic [LEVEL_W-1:0] red_level   = '0;
  logic [LEVEL_W-1:0] green_level = '0;
  logic [LEVEL_W-1:0] blue_level  = '0;
  logic               out_valid_o;
  logic               out_stall = 1'b0;
  logic [GRB_W-1:0]   grb_word_o;

  led_temporal_dither #(
    .STRING_LENGTH(PIXELS)
  ) u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_n),
    .cfg_we_i     (cfg_we),
    .cfg_wdata_i  (cfg_wdata),
    .in_valid_i   (in_valid),
    .in_stall_o   (in_stall_o),
    .pixel_index_i(pixel_index),
    .red_level_i  (red_level),
    .green_level_i(green_level),
    .blue_level_i (blue_level),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall),
    .grb_word_o   (grb_word_o)
  );

  // Pending pixels, expected words and the predictor's own state
  pixel_item_t        pixel_q[$];
  logic [GRB_W-1:0]   grb_expect_q[$];
  logic [DEPTH_W-1:0] depth_shadow = DEPTH_RESET;
  logic [RES_W-1:0]   residue_mem[3][PIXELS];
  int unsigned        mismatches = 0;
  bit                 no_idle    = 1'b0;
  bit                 hold_req   = 1'b0;

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Register value mapped into the supported depth range
  function automatic int unsigned clamp_depth(logic [DEPTH_W-1:0] d);
    if (d < DEPTH_MIN) return DEPTH_MIN;
    if (d > DEPTH_MAX) return DEPTH_MAX;
    return d;
  endfunction

  // One channel: add residue, keep top 8 bits (saturated), store dropped bits
  function automatic logic [CHAN_W-1:0] dither_chan(logic [LEVEL_W-1:0] level, int c,
                                                    logic [IDX_W-1:0] idx);
    int unsigned      d;
    int unsigned      shift;
    logic [16:0]      mask;
    logic [16:0]      sum;
    logic [16:0]      value;
    logic [RES_W-1:0] res;
    d     = clamp_depth(depth_shadow);
    shift = d - 8;
    mask  = (17'd1 << d) - 17'd1;
    res   = (idx < PIXELS) ? residue_mem[c][idx] : '0;
    sum   = ({1'b0, level} & mask) + res;
    value = sum >> shift;
    if (idx < PIXELS) residue_mem[c][idx] = RES_W'(sum & ((17'd1 << shift) - 17'd1));
    return (value > 17'd255) ? 8'hFF : value[7:0];
  endfunction

  function automatic logic [GRB_W-1:0] dither_pixel(logic [IDX_W-1:0] idx,
                                                    logic [LEVEL_W-1:0] r,
                                                    logic [LEVEL_W-1:0] g,
                                                    logic [LEVEL_W-1:0] b);
    logic [CHAN_W-1:0] rv;
    logic [CHAN_W-1:0] gv;
    logic [CHAN_W-1:0] bv;
    rv = dither_chan(r, 0, idx);
    gv = dither_chan(g, 1, idx);
    bv = dither_chan(b, 2, idx);
    return {gv, rv, bv};
  endfunction

  // Driver: presents queued pixels, waiting each item's gap first
  int unsigned tx_gap_cnt = 0;
  pixel_item_t tx_cur;

  always @(posedge clk_i) begin
    if (rst_n) begin
      if (in_valid && !in_stall_o)
        grb_expect_q.push_back(dither_pixel(pixel_index, red_level, green_level, blue_level));
      if (!in_valid || !in_stall_o) begin
        if (pixel_q.size() > 0 && tx_gap_cnt < pixel_q[0].gap) begin
          tx_gap_cnt++;
          in_valid <= 1'b0;
        end else if (pixel_q.size() > 0) begin
          tx_cur      = pixel_q.pop_front();
          tx_gap_cnt  = 0;
          in_valid    <= 1'b1;
          pixel_index <= tx_cur.idx;
          red_level   <= tx_cur.red;
          green_level <= tx_cur.green;
          blue_level  <= tx_cur.blue;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: checks each word, then draws its own stall for the next one
  int unsigned      rx_stall_left = 0;
  int unsigned      rx_hold_left  = 0;
  bit               rx_hold_done  = 1'b0;
  logic [GRB_W-1:0] rx_exp;

  always @(posedge clk_i) begin
    if (rst_n) begin
      if (out_valid_o && !out_stall) begin
        if (grb_expect_q.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected grb_word, expected none, got %06h", $time, grb_word_o);
        end else begin
          rx_exp = grb_expect_q.pop_front();
          if (grb_word_o !== rx_exp) begin
            mismatches++;
            $display("%0t: grb_word mismatch, expected %06h, got %06h",
                     $time, rx_exp, grb_word_o);
          end
        end
        rx_stall_left = no_idle ? 0 : $urandom_range(0, 19);
      end
      // one long hold-off so the pipeline fills and stalls its input
      if (hold_req && !rx_hold_done) begin
        rx_hold_left = HOLD_CYCLES;
        rx_hold_done = 1'b1;
      end
      out_stall <= (rx_hold_left > 0) || (rx_stall_left > 0);
      if (rx_hold_left > 0) rx_hold_left--;
      if (rx_stall_left > 0) rx_stall_left--;
    end
  end

  // Watchdog on cycles without any handshake
  int unsigned stuck_cycles = 0;

  always @(posedge clk_i) begin
    if (rst_n) begin
      if ((in_valid && !in_stall_o) || (out_valid_o && !out_stall)) begin
        stuck_cycles = 0;
      end else if (stuck_cycles + 1 >= STUCK_LIMIT) begin
        $display("Mismatches found");
        $finish;
      end else begin
        stuck_cycles++;
      end
    end
  end

  task automatic add_pixel(logic [IDX_W-1:0] idx, logic [LEVEL_W-1:0] r,
                           logic [LEVEL_W-1:0] g, logic [LEVEL_W-1:0] b);
    pixel_item_t it;
    it.idx   = idx;
    it.red   = r;
    it.green = g;
    it.blue  = b;
    it.gap   = no_idle ? 0 : $urandom_range(0, 19);
    pixel_q.push_back(it);
  endtask

  // Intensity biased toward zero, full scale and stray upper bits
  function automatic logic [LEVEL_W-1:0] pick_level(int unsigned d);
    logic [16:0] top;
    top = (17'd1 << d) - 17'd1;
    case ($urandom_range(0, 3))
      0:       return LEVEL_W'($urandom);
      1:       return top[15:0] - LEVEL_W'($urandom_range(0, 15));
      2:       return LEVEL_W'($urandom_range(0, 15));
      default: return LEVEL_W'($urandom) & top[15:0];
    endcase
  endfunction

  // Sender pause: everything sent and every expected word received
  task automatic wait_idle();
    @(negedge clk_i);
    while (pixel_q.size() != 0 || in_valid || grb_expect_q.size() != 0)
      @(negedge clk_i);
    repeat (3) @(posedge clk_i);
  endtask

  task automatic write_depth(logic [DEPTH_W-1:0] d);
    @(posedge clk_i);
    cfg_we    <= 1'b1;
    cfg_wdata <= d;
    @(posedge clk_i);
    cfg_we       <= 1'b0;
    depth_shadow = d;
    @(negedge clk_i);
  endtask

  int unsigned depth_plan[14] = '{8, 16, 0, 31, 7, 17, 12, 9, 13, 15, 11, 10, 14, 16};

  initial begin
    for (int c = 0; c < 3; c++)
      for (int p = 0; p < PIXELS; p++)
        residue_mem[c][p] = '0;
    repeat (12) @(posedge clk_i);
    rst_n <= 1'b1;
    @(negedge clk_i);

    // Reset depth: extremes, stray upper bits, fraction buildup, saturation
    add_pixel(5'd0, 16'h0000, 16'h0000, 16'h0000);
    add_pixel(5'd31, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    add_pixel(5'd5, 16'h0FFF, 16'h0800, 16'h0001);
    add_pixel(5'd5, 16'h0FFF, 16'h0FFF, 16'h0FFF);
    add_pixel(5'd5, 16'h0FFF, 16'h0FF8, 16'h000F);
    add_pixel(5'd7, 16'hF123, 16'h1ABC, 16'h8000);
    for (int k = 0; k < 4; k++)
      add_pixel(5'd3, 16'h0018, 16'h0007, 16'h0FF9);
    add_pixel(5'd31, 16'h0FFF, 16'h0FFF, 16'h0FFF);

    for (int ph = 0; ph < 14; ph++) begin
      wait_idle();
      write_depth(DEPTH_W'(depth_plan[ph]));
      no_idle = (ph == 2 || ph == 5 || ph == 9);
      // depth of eight: residue always zero; depth sixteen: saturation
      if (ph == 0) begin
        add_pixel(5'd1, 16'hFFFF, 16'h12AB, 16'h0000);
        add_pixel(5'd1, 16'h00FF, 16'h0080, 16'h0001);
      end
      if (ph == 1) begin
        add_pixel(5'd2, 16'hFFFF, 16'hFF80, 16'h00FF);
        add_pixel(5'd2, 16'hFFFF, 16'hFF80, 16'h00FF);
        add_pixel(5'd2, 16'h0001, 16'hFFFF, 16'h8000);
      end
      if (ph == 2) hold_req = 1'b1;
      for (int n = 0; n < RAND_ITEMS; n++) begin
        int unsigned d;
        d = clamp_depth(depth_shadow);
        add_pixel(($urandom_range(0, 1) == 0) ? IDX_W'($urandom_range(0, 3))
                                               : IDX_W'($urandom),
                  pick_level(d), pick_level(d), pick_level(d));
      end
    end

    wait_idle();
    repeat (10) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
